// ===== rtl/msr_pkg.sv =====
// Shared constants and types for the mark range stream splitter.
package msr_pkg;

    localparam int TOTAL_W      = 32;
    localparam int THREAD_W     = 16;
    localparam int MIN_SPLIT_W  = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int GS_W         = 33;
    localparam int PART_MARKS_W = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREADS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT = 2'd2;

    typedef struct packed {
        logic first;
        logic lastp;
    } item_flags_t;

endpackage

// ===== rtl/msr_div.sv =====
// Iterative divider that derives the read group size from the configuration.
module msr_div
    import msr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TOTAL_W-1:0]  dividend,
    input  logic [THREAD_W-1:0] divisor,
    output logic [GS_W-1:0]     group_size,
    output logic                busy
);

    localparam int STEP_W = $clog2(TOTAL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_W - 1);

    logic                run_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [GS_W-1:0]     gs_reg;
    logic [TOTAL_W-1:0]  quo_reg;
    logic [THREAD_W-1:0] rem_reg;
    logic [THREAD_W-1:0] dvs_reg;

    logic [THREAD_W:0]   shifted;
    logic [THREAD_W:0]   diff;
    logic                take;
    logic [THREAD_W-1:0] rem_next;
    logic [TOTAL_W-1:0]  quo_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[TOTAL_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        take     = shifted >= {1'b0, dvs_reg};
        rem_next = take ? diff[THREAD_W-1:0] : shifted[THREAD_W-1:0];
        quo_next = {quo_reg[TOTAL_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            gs_reg   <= GS_W'(1);
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_reg <= 1'b0;
                gs_reg  <= {1'b0, quo_next} + GS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= (divisor == '0) ? THREAD_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign group_size = gs_reg;
    assign busy       = run_reg || start;

endmodule

// ===== rtl/msr_queue.sv =====
// Short queue between the intake stage and the splitting engine.
module msr_queue
    import msr_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] data,
    output logic              empty,
    output logic              full
);

    logic [DATA_W-1:0]  mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign data  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));

endmodule

// ===== rtl/msr_front.sv =====
// Intake stage: accepts ranges, clamps the end mark and sizes the range.
module msr_front
    import msr_pkg::*;
#(
    parameter int MARK_BITS     = 32,
    parameter int PART_TAG_BITS = 16,
    localparam int ITEM_W = PART_TAG_BITS + PART_MARKS_W + $bits(item_flags_t) + 3 * MARK_BITS
)
(
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [MARK_BITS-1:0]     range_begin,
    input  logic [MARK_BITS-1:0]     range_end,
    input  logic [PART_TAG_BITS-1:0] part_id,
    input  logic [PART_MARKS_W-1:0]  part_marks,
    input  logic                     first_of_part,
    input  logic                     last_of_part,
    input  logic                     busy,
    input  logic                     q_full,
    output logic                     push,
    output logic [ITEM_W-1:0]        push_data
);

    logic [MARK_BITS-1:0] end_c;
    logic [MARK_BITS-1:0] size;
    item_flags_t          flags;

    always_comb
    begin
        // an end below the begin means an empty range
        end_c       = (range_end < range_begin) ? range_begin : range_end;
        size        = end_c - range_begin;
        flags.first = first_of_part;
        flags.lastp = last_of_part;
    end

    assign in_stall  = q_full || busy;
    assign push      = in_valid && !in_stall;
    assign push_data = {part_id, part_marks, flags, range_begin, end_c, size};

endmodule

// ===== rtl/msr_back.sv =====
// Splitting engine: cuts ranges into read group pieces and drives the result register.
module msr_back
    import msr_pkg::*;
#(
    parameter int MARK_BITS     = 32,
    parameter int PART_TAG_BITS = 16,
    parameter int MAX_PIECES    = 64,
    localparam int ITEM_W = PART_TAG_BITS + PART_MARKS_W + $bits(item_flags_t) + 3 * MARK_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ITEM_W-1:0]        q_data,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  logic [GS_W-1:0]          group_size,
    input  logic [MIN_SPLIT_W-1:0]   min_split_marks,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [MARK_BITS-1:0]     piece_begin,
    output logic [MARK_BITS-1:0]     piece_end,
    output logic [PART_TAG_BITS-1:0] piece_part,
    output logic                     group_end,
    output logic                     last,
    output logic                     overflow
);

    localparam int WW    = ((MARK_BITS > GS_W) ? MARK_BITS : GS_W) + 1;
    localparam int CNT_W = $clog2(MAX_PIECES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PIECES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PIECES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OPEN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_CUT   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;

    // queue entry fields
    logic [PART_TAG_BITS-1:0] q_tag;
    logic [PART_MARKS_W-1:0]  q_pm;
    item_flags_t              q_flags;
    logic [MARK_BITS-1:0]     q_b;
    logic [MARK_BITS-1:0]     q_e;
    logic [MARK_BITS-1:0]     q_rm;

    // held item
    logic [PART_TAG_BITS-1:0] tag_reg;
    logic [PART_MARKS_W-1:0]  pm_reg;
    item_flags_t              flags_reg;
    logic [MARK_BITS-1:0]     ib_reg;
    logic [MARK_BITS-1:0]     ie_reg;
    logic [MARK_BITS-1:0]     irm_reg;

    logic [PART_MARKS_W-1:0]  src_pm;
    item_flags_t              src_flags;
    logic [MARK_BITS-1:0]     src_b;
    logic [MARK_BITS-1:0]     src_rm;

    // sequencer and working state
    logic [2:0]              state_reg, state_next;
    logic                    pass_reg, pass_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MARK_BITS-1:0]    b_reg, b_next;
    logic [MARK_BITS-1:0]    rm_reg, rm_next;
    logic [PART_MARKS_W-1:0] pml_reg, pml_next;
    logic [WW-1:0]           gm_reg, gm_next;
    logic                    tail_reg, tail_next;
    logic                    ing_reg, ing_next;

    // state between items
    logic [PART_MARKS_W-1:0] cpml_reg;
    logic [WW-1:0]           cgm_reg;
    logic                    ctail_reg;
    logic                    cing_reg;

    // decision registers
    logic [WW-1:0]           sum_reg, sum_next;
    logic                    split_reg, split_next;
    logic [WW-1:0]           n0_reg, n0_next;
    logic [MARK_BITS-1:0]    rmm_reg, rmm_next;
    logic [MARK_BITS-1:0]    n_reg, n_next;
    logic [WW-1:0]           gspm_reg;

    logic [WW-1:0]           gs_x;
    logic [WW-1:0]           m_x;
    logic [WW-1:0]           rm_x;
    logic [WW-1:0]           n1;
    logic                    can_emit;
    logic                    emit_ok;
    logic                    piece;
    logic                    wr;
    logic [MARK_BITS-1:0]    p_begin;
    logic [MARK_BITS-1:0]    p_end;
    logic                    p_ge;
    logic                    p_last;
    logic                    done;
    logic                    load;
    logic                    capture;
    logic                    commit;

    logic                     out_valid_reg;
    logic [MARK_BITS-1:0]     pb_reg;
    logic [MARK_BITS-1:0]     pe_reg;
    logic [PART_TAG_BITS-1:0] pp_reg;
    logic                     ge_reg;
    logic                     last_reg;
    logic                     ovfo_reg;

    function automatic logic [PART_MARKS_W-1:0] sat_sub(
        input logic [PART_MARKS_W-1:0] a,
        input logic [WW-1:0]           x
    );
        logic [WW-1:0] ax;
        ax = WW'(a);
        return (ax > x) ? PART_MARKS_W'(ax - x) : '0;
    endfunction

    assign q_tag   = q_data[ITEM_W-1 -: PART_TAG_BITS];
    assign q_pm    = q_data[ITEM_W-PART_TAG_BITS-1 -: PART_MARKS_W];
    assign q_flags = item_flags_t'(q_data[3*MARK_BITS +: $bits(item_flags_t)]);
    assign q_b     = q_data[2*MARK_BITS +: MARK_BITS];
    assign q_e     = q_data[MARK_BITS +: MARK_BITS];
    assign q_rm    = q_data[0 +: MARK_BITS];

    assign src_pm    = (state_reg == S_IDLE) ? q_pm    : pm_reg;
    assign src_flags = (state_reg == S_IDLE) ? q_flags : flags_reg;
    assign src_b     = (state_reg == S_IDLE) ? q_b     : ib_reg;
    assign src_rm    = (state_reg == S_IDLE) ? q_rm    : irm_reg;

    assign gs_x     = WW'(group_size);
    assign m_x      = WW'(min_split_marks);
    assign rm_x     = WW'(rm_reg);
    assign can_emit = !out_valid_reg || !out_stall;
    // the counting pass never waits on the receiver
    assign emit_ok  = !pass_reg || can_emit;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        b_next     = b_reg;
        rm_next    = rm_reg;
        pml_next   = pml_reg;
        gm_next    = gm_reg;
        tail_next  = tail_reg;
        ing_next   = ing_reg;
        sum_next   = sum_reg;
        split_next = split_reg;
        n0_next    = n0_reg;
        rmm_next   = rmm_reg;
        n_next     = n_reg;
        n1         = '0;
        piece      = 1'b0;
        p_begin    = b_reg;
        p_end      = ie_reg;
        p_ge       = 1'b0;
        p_last     = 1'b0;
        done       = 1'b0;
        load       = 1'b0;
        capture    = 1'b0;
        commit     = 1'b0;
        q_pop      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    capture   = 1'b1;
                    load      = 1'b1;
                    ovf_next  = 1'b0;
                    pass_next = 1'b0;
                end
            end
            S_OPEN:
            begin
                if (!ing_reg)
                begin
                    ing_next  = 1'b1;
                    gm_next   = '0;
                    tail_next = WW'(pml_reg) <= gs_x;
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cnt_reg == MAX_CNT)
                begin
                    // piece limit: rest of the range counts as consumed
                    ovf_next = 1'b1;
                    pml_next = sat_sub(pml_reg, rm_x);
                    done     = 1'b1;
                end
                else if (tail_reg)
                begin
                    if (emit_ok)
                    begin
                        piece    = 1'b1;
                        p_ge     = flags_reg.lastp;
                        p_last   = 1'b1;
                        pml_next = sat_sub(pml_reg, rm_x);
                        done     = 1'b1;
                    end
                end
                else
                begin
                    sum_next   = rm_x + gm_reg;
                    split_next = (rm_x + gm_reg > gs_x) && (rm_x >= (m_x << 1))
                                 && (rm_x + gm_reg > gspm_reg);
                    n0_next    = gs_x - gm_reg;
                    rmm_next   = rm_reg - MARK_BITS'(min_split_marks);
                    state_next = S_CUT;
                end
            end
            S_CUT:
            begin
                if (split_reg)
                begin
                    n1         = (n0_reg < m_x) ? m_x : n0_reg;
                    n_next     = (n1 > WW'(rmm_reg)) ? rmm_reg : MARK_BITS'(n1);
                    state_next = S_SPLIT;
                end
                else if (emit_ok)
                begin
                    piece    = 1'b1;
                    p_ge     = (sum_reg >= gs_x) || flags_reg.lastp;
                    p_last   = 1'b1;
                    gm_next  = sum_reg;
                    pml_next = sat_sub(pml_reg, rm_x);
                    if (p_ge)
                    begin
                        ing_next = 1'b0;
                    end
                    done = 1'b1;
                end
            end
            S_SPLIT:
            begin
                if (emit_ok)
                begin
                    piece      = 1'b1;
                    p_end      = b_reg + n_reg;
                    p_ge       = 1'b1;
                    p_last     = (cnt_reg == LAST_CNT);
                    b_next     = b_reg + n_reg;
                    rm_next    = rm_reg - n_reg;
                    pml_next   = sat_sub(pml_reg, WW'(n_reg));
                    ing_next   = 1'b0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_OPEN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // first pass only counts pieces; the second one emits them
        if (done)
        begin
            if (!pass_reg)
            begin
                pass_next = 1'b1;
                load      = 1'b1;
            end
            else
            begin
                commit     = 1'b1;
                state_next = S_IDLE;
            end
        end

        if (load)
        begin
            b_next     = src_b;
            rm_next    = src_rm;
            cnt_next   = '0;
            pml_next   = src_flags.first ? src_pm : cpml_reg;
            gm_next    = src_flags.first ? '0 : cgm_reg;
            tail_next  = src_flags.first ? 1'b0 : ctail_reg;
            ing_next   = src_flags.first ? 1'b0 : cing_reg;
            state_next = S_OPEN;
        end
    end

    assign wr = piece && pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            b_reg         <= '0;
            rm_reg        <= '0;
            pml_reg       <= '0;
            gm_reg        <= '0;
            tail_reg      <= 1'b0;
            ing_reg       <= 1'b0;
            cpml_reg      <= '0;
            cgm_reg       <= '0;
            ctail_reg     <= 1'b0;
            cing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            b_reg     <= b_next;
            rm_reg    <= rm_next;
            pml_reg   <= pml_next;
            gm_reg    <= gm_next;
            tail_reg  <= tail_next;
            ing_reg   <= ing_next;
            if (commit)
            begin
                cpml_reg  <= pml_next;
                cgm_reg   <= flags_reg.lastp ? '0 : gm_next;
                ctail_reg <= flags_reg.lastp ? 1'b0 : tail_next;
                cing_reg  <= flags_reg.lastp ? 1'b0 : ing_next;
            end
            if (wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gspm_reg  <= gs_x + m_x;
        sum_reg   <= sum_next;
        split_reg <= split_next;
        n0_reg    <= n0_next;
        rmm_reg   <= rmm_next;
        n_reg     <= n_next;
        if (capture)
        begin
            tag_reg   <= q_tag;
            pm_reg    <= q_pm;
            flags_reg <= q_flags;
            ib_reg    <= q_b;
            ie_reg    <= q_e;
            irm_reg   <= q_rm;
        end
        if (wr)
        begin
            pb_reg   <= p_begin;
            pe_reg   <= p_end;
            pp_reg   <= tag_reg;
            ge_reg   <= p_ge;
            last_reg <= p_last;
            ovfo_reg <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign piece_begin = pb_reg;
    assign piece_end   = pe_reg;
    assign piece_part  = pp_reg;
    assign group_end   = ge_reg;
    assign last        = last_reg;
    assign overflow    = ovfo_reg;

endmodule

// ===== rtl/mark_range_stream_splitter_top.sv =====
// Top level of the mark range stream splitter.
//
// Input channel (in_valid / in_stall) takes one mark range per transfer, in part
// order. Output channel (out_valid / out_stall) gives the pieces of each range in
// order; the final piece of a range carries last, and every piece of a truncated
// range carries overflow. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata); write it only while no range is in flight.
// A write of the total mark count or the thread count starts the group size
// divider, which yields one quotient bit a cycle; in_stall is high while it runs.
// Each range is run twice by the splitting sequencer: a counting pass that finds
// whether the piece limit is hit, then the emitting pass. The range is popped in the
// idle state; in each pass a cut goes through the open, evaluate, cut and split states,
// and the closing piece through open, evaluate and cut (open and evaluate alone in a
// tail group). A two-entry queue lets intake run ahead of the sequencer.
// After reset the group size is 1, no part is open and the queue is empty.
// When out_stall is high with out_valid set, the result register holds; the emitting
// pass waits at the next piece and the queue fills, after which in_stall rises.
module mark_range_stream_splitter_top
    import msr_pkg::*;
#(
    parameter int MAX_PIECES    = 64,
    parameter int MARK_BITS     = 32,
    parameter int PART_TAG_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [MARK_BITS-1:0]     range_begin,
    input  logic [MARK_BITS-1:0]     range_end,
    input  logic [PART_TAG_BITS-1:0] part_id,
    input  logic [PART_MARKS_W-1:0]  part_marks,
    input  logic                     first_of_part,
    input  logic                     last_of_part,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [MARK_BITS-1:0]     piece_begin,
    output logic [MARK_BITS-1:0]     piece_end,
    output logic [PART_TAG_BITS-1:0] piece_part,
    output logic                     group_end,
    output logic                     last,
    output logic                     overflow
);

    localparam int ITEM_W = PART_TAG_BITS + PART_MARKS_W + $bits(item_flags_t) + 3 * MARK_BITS;

    logic [TOTAL_W-1:0]     total_reg;
    logic [THREAD_W-1:0]    thread_reg;
    logic [MIN_SPLIT_W-1:0] min_split_reg;
    logic                   start_reg;

    logic [GS_W-1:0]   group_size;
    logic              busy;
    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    logic [ITEM_W-1:0] push_data;
    logic [ITEM_W-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            thread_reg    <= THREAD_W'(1);
            min_split_reg <= '0;
            start_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_we && ((cfg_index == CFG_TOTAL) || (cfg_index == CFG_THREADS));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL:     total_reg     <= cfg_wdata[TOTAL_W-1:0];
                    CFG_THREADS:   thread_reg    <= cfg_wdata[THREAD_W-1:0];
                    CFG_MIN_SPLIT: min_split_reg <= cfg_wdata[MIN_SPLIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    msr_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .dividend   (total_reg),
        .divisor    (thread_reg),
        .group_size (group_size),
        .busy       (busy)
    );

    msr_front #(
        .MARK_BITS     (MARK_BITS),
        .PART_TAG_BITS (PART_TAG_BITS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .range_begin   (range_begin),
        .range_end     (range_end),
        .part_id       (part_id),
        .part_marks    (part_marks),
        .first_of_part (first_of_part),
        .last_of_part  (last_of_part),
        .busy          (busy),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    msr_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .data      (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    msr_back #(
        .MARK_BITS     (MARK_BITS),
        .PART_TAG_BITS (PART_TAG_BITS),
        .MAX_PIECES    (MAX_PIECES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_data          (q_data),
        .q_empty         (q_empty),
        .q_pop           (pop),
        .group_size      (group_size),
        .min_split_marks (min_split_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .piece_begin     (piece_begin),
        .piece_end       (piece_end),
        .piece_part      (piece_part),
        .group_end       (group_end),
        .last            (last),
        .overflow        (overflow)
    );

endmodule

// ===== rtl/msr_chk.sv =====
// Port-level checker for the mark range stream splitter, bound to the top level.
module msr_chk
#(
    parameter int MARK_BITS     = 32,
    parameter int PART_TAG_BITS = 16
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [MARK_BITS-1:0]     piece_begin,
    input logic [MARK_BITS-1:0]     piece_end,
    input logic [PART_TAG_BITS-1:0] piece_part,
    input logic                     group_end,
    input logic                     last,
    input logic                     overflow
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(piece_begin)
            && $stable(piece_end) && $stable(piece_part) && $stable(last)
            && $stable(overflow))
        else $error("stalled result changed");

    // a piece never ends below its begin
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> piece_end >= piece_begin)
        else $error("piece end below piece begin");

    // only cuts leave more pieces to come, and a cut is never empty
    a_cut: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> group_end && (piece_end != piece_begin))
        else $error("non-final piece is not a proper cut");

endmodule

bind mark_range_stream_splitter_top msr_chk #(
    .MARK_BITS     (MARK_BITS),
    .PART_TAG_BITS (PART_TAG_BITS)
) u_msr_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .piece_begin (piece_begin),
    .piece_end   (piece_end),
    .piece_part  (piece_part),
    .group_end   (group_end),
    .last        (last),
    .overflow    (overflow)
);
